// File: rtl/prsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package prsr_pkg;

  // Frame layout
  localparam logic [7:0] LEN_BYTE_POS = 8'd25;
  localparam logic [7:0] SSID_START   = 8'd26;
  localparam logic [7:0] OFF_MAX      = 8'd255;

  // Frame-control low byte: type in bits 3:2, subtype in bits 7:4
  localparam logic [1:0] TYPE_MGMT     = 2'h0;
  localparam logic [3:0] SUBTYPE_PROBE = 4'h4;

  // Stored length saturates to fit the 6-bit length field
  localparam logic [5:0] LEN_MAX = 6'd63;

  // Running SSID byte sum, reduced by reciprocal multiplication at frame end
  localparam int SUM_W = 16;

  // Result kinds
  localparam logic [1:0] KIND_RECORDED = 2'd0;
  localparam logic [1:0] KIND_IGNORED  = 2'd1;
  localparam logic [1:0] KIND_READ     = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_DIV,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_FINISH,
    ST_PUT
  } prsr_state_t;

  typedef struct packed {
    logic accept;
    logic res_read;
    logic res_ignore;
    logic div_start;
    logic div_step;
    logic copy_rd;
    logic copy_wr;
    logic res_record;
    logic out_load;
  } prsr_cmd_t;

  typedef struct packed {
    logic keep_ok;
    logic div_last;
    logic copy_last;
    logic out_free;
  } prsr_sts_t;

endpackage

`default_nettype wire

// File: rtl/prsr_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface prsr_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] byte_value;
  logic       last_byte;
  logic [3:0] read_slot;
  logic [4:0] read_position;

  modport source (output valid, command, byte_value, last_byte, read_slot, read_position,
                  input ready);
  modport sink   (input valid, command, byte_value, last_byte, read_slot, read_position,
                  output ready);
endinterface

interface prsr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] slot;
  logic [7:0] data;
  logic [5:0] length;

  modport source (output valid, kind, slot, data, length, input ready);
  modport sink   (input valid, kind, slot, data, length, output ready);
endinterface

`default_nettype wire

// File: rtl/prsr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module prsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/prsr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module prsr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_command,
  input  wire logic                in_last,
  output logic                     in_ready,
  input  wire prsr_pkg::prsr_sts_t sts,
  output prsr_pkg::prsr_cmd_t      cmd
);

  prsr_pkg::prsr_state_t state_r, state_nxt;
  logic accept;

  assign in_ready = (state_r == prsr_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= prsr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      prsr_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_command) begin
            state_nxt = prsr_pkg::ST_READ;
          end else if (in_last) begin
            state_nxt = prsr_pkg::ST_CHECK;
          end
        end
      end
      prsr_pkg::ST_READ:    state_nxt = prsr_pkg::ST_PUT;
      prsr_pkg::ST_CHECK: begin
        state_nxt = sts.keep_ok ? prsr_pkg::ST_DIV : prsr_pkg::ST_PUT;
      end
      prsr_pkg::ST_DIV: begin
        if (sts.div_last) begin
          state_nxt = prsr_pkg::ST_COPY_RD;
        end
      end
      prsr_pkg::ST_COPY_RD: state_nxt = prsr_pkg::ST_COPY_WR;
      prsr_pkg::ST_COPY_WR: begin
        state_nxt = sts.copy_last ? prsr_pkg::ST_FINISH : prsr_pkg::ST_COPY_RD;
      end
      prsr_pkg::ST_FINISH:  state_nxt = prsr_pkg::ST_PUT;
      prsr_pkg::ST_PUT: begin
        if (sts.out_free) begin
          state_nxt = prsr_pkg::ST_IDLE;
        end
      end
      default:              state_nxt = prsr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      prsr_pkg::ST_IDLE:    cmd.accept   = accept;
      prsr_pkg::ST_READ:    cmd.res_read = 1'b1;
      prsr_pkg::ST_CHECK: begin
        if (sts.keep_ok) begin
          cmd.div_start = 1'b1;
        end else begin
          cmd.res_ignore = 1'b1;
        end
      end
      prsr_pkg::ST_DIV:     cmd.div_step   = 1'b1;
      prsr_pkg::ST_COPY_RD: cmd.copy_rd    = 1'b1;
      prsr_pkg::ST_COPY_WR: cmd.copy_wr    = 1'b1;
      prsr_pkg::ST_FINISH:  cmd.res_record = 1'b1;
      prsr_pkg::ST_PUT:     cmd.out_load   = sts.out_free;
      default:              cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/prsr_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module prsr_dpath #(
  parameter int SLOTS      = 16,
  parameter int SSID_BYTES = 33
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire prsr_pkg::prsr_cmd_t cmd,
  output prsr_pkg::prsr_sts_t      sts,
  input  wire logic                in_command,
  input  wire logic [7:0]          in_byte_value,
  input  wire logic [3:0]          in_read_slot,
  input  wire logic [4:0]          in_read_position,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               out_kind,
  output logic [3:0]               out_slot,
  output logic [7:0]               out_data,
  output logic [5:0]               out_length
);

  localparam int KEEP = SSID_BYTES - 1;
  localparam int RW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW   = (KEEP > 1) ? $clog2(KEEP) : 1;
  localparam int AW   = RW + PW;
  localparam logic [8:0]  SLOTS_9 = SLOTS[8:0];
  localparam logic [7:0]  KEEP_V  = KEEP[7:0];

  // Reciprocal of SLOTS, rounded up, exact for every sum below 2**SUM_W
  localparam int RECIP_SH = prsr_pkg::SUM_W + RW;
  localparam int RECIP_W  = prsr_pkg::SUM_W + 2;
  localparam int PROD_W   = prsr_pkg::SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** RECIP_SH + SLOTS - 1) / SLOTS);
  localparam logic [RW-1:0]      SLOTS_LO = SLOTS[RW-1:0];

  // Frame state
  logic [7:0]                   off_r, fc_r, ssid_len_r, seen_r;
  logic [prsr_pkg::SUM_W-1:0]   sum_r;
  logic                         frame_acc, ssid_byte, frame_clr;

  // Remainder and copy sequencing
  logic [RW-1:0]     rem_r;
  logic [PROD_W-1:0] recip_prod;
  logic [RW-1:0]     quo_lo, quo_lo_r;
  logic [2*RW-1:0]   quo_mul;
  logic [RW-1:0]     rem_nxt;
  logic              div_cnt_r;
  logic [PW-1:0]     copy_idx_r;
  logic [7:0]        keep_r, keep_nxt;
  logic [5:0]        stored_len;

  // Slot lengths and read latch
  logic [5:0] slot_len_r [SLOTS];
  logic       read_acc, slot_in;
  logic [5:0] len_sel;
  logic [3:0] rd_slot_r;
  logic [5:0] rd_len_r;
  logic       rd_ok_r;

  // Result and output registers
  logic [1:0] res_kind_r;
  logic [3:0] res_slot_r;
  logic [7:0] res_data_r;
  logic [5:0] res_len_r;
  logic       out_valid_r;
  logic [1:0] out_kind_r;
  logic [3:0] out_slot_r;
  logic [7:0] out_data_r;
  logic [5:0] out_len_r;

  // Memory ports
  logic          stg_we;
  logic [7:0]    stg_rdata, tbl_rdata;
  logic [AW-1:0] tbl_raddr, tbl_waddr;

  assign frame_acc = cmd.accept && !in_command;
  assign read_acc  = cmd.accept && in_command;
  assign frame_clr = cmd.res_ignore || cmd.res_record;
  assign ssid_byte = (off_r >= prsr_pkg::SSID_START) && (seen_r < ssid_len_r);
  assign stg_we    = frame_acc && ssid_byte && (seen_r < KEEP_V);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r      <= '0;
      fc_r       <= '0;
      ssid_len_r <= '0;
      seen_r     <= '0;
      sum_r      <= '0;
    end else if (frame_clr) begin
      off_r      <= '0;
      fc_r       <= '0;
      ssid_len_r <= '0;
      seen_r     <= '0;
      sum_r      <= '0;
    end else if (frame_acc) begin
      if (off_r == 8'd0) begin
        fc_r <= in_byte_value;
      end else if (off_r == prsr_pkg::LEN_BYTE_POS) begin
        ssid_len_r <= in_byte_value;
      end else if (ssid_byte) begin
        sum_r  <= sum_r + prsr_pkg::SUM_W'(in_byte_value);
        seen_r <= seen_r + 8'd1;
      end
      if (off_r != prsr_pkg::OFF_MAX) begin
        off_r <= off_r + 8'd1;
      end
    end
  end

  assign sts.keep_ok = (fc_r[3:2] == prsr_pkg::TYPE_MGMT)
                    && (fc_r[7:4] == prsr_pkg::SUBTYPE_PROBE)
                    && (off_r >= prsr_pkg::SSID_START)
                    && (seen_r == ssid_len_r)
                    && (ssid_len_r != 8'd0);

  // Remainder of the byte sum by SLOTS in two steps: take the low quotient bits
  // from the reciprocal product, then subtract quotient times SLOTS modulo 2**RW
  assign recip_prod = PROD_W'(sum_r) * PROD_W'(RECIP);
  assign quo_lo     = recip_prod[RECIP_SH +: RW];
  assign quo_mul    = (2*RW)'(quo_lo_r) * (2*RW)'(SLOTS_LO);
  assign rem_nxt    = sum_r[RW-1:0] - quo_mul[RW-1:0];
  assign keep_nxt   = (ssid_len_r > KEEP_V) ? KEEP_V : ssid_len_r;
  assign stored_len = (keep_r > 8'(prsr_pkg::LEN_MAX)) ? prsr_pkg::LEN_MAX : keep_r[5:0];

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_cnt_r  <= 1'b1;
      copy_idx_r <= '0;
      keep_r     <= keep_nxt;
    end else begin
      if (cmd.div_step) begin
        if (div_cnt_r) begin
          quo_lo_r <= quo_lo;
        end else begin
          rem_r <= rem_nxt;
        end
        div_cnt_r <= 1'b0;
      end
      if (cmd.copy_wr) begin
        copy_idx_r <= copy_idx_r + PW'(1);
      end
    end
  end

  assign sts.div_last  = !div_cnt_r;
  assign sts.copy_last = (8'(copy_idx_r) == (keep_r - 8'd1));

  prsr_ram #(
    .WIDTH (8),
    .DEPTH (2 ** PW)
  ) u_stage_ram (
    .clk   (clk),
    .we    (stg_we),
    .waddr (seen_r[PW-1:0]),
    .wdata (in_byte_value),
    .re    (cmd.copy_rd),
    .raddr (copy_idx_r),
    .rdata (stg_rdata)
  );

  assign tbl_waddr = {rem_r, copy_idx_r};
  assign tbl_raddr = {RW'(in_read_slot), PW'(in_read_position)};

  prsr_ram #(
    .WIDTH (8),
    .DEPTH (2 ** AW)
  ) u_table_ram (
    .clk   (clk),
    .we    (cmd.copy_wr),
    .waddr (tbl_waddr),
    .wdata (stg_rdata),
    .re    (read_acc),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // Slot lengths gate every table read, so the table itself needs no clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_len_r[i] <= '0;
      end
    end else if (cmd.res_record) begin
      slot_len_r[rem_r] <= stored_len;
    end
  end

  assign slot_in = (9'(in_read_slot) < SLOTS_9);
  assign len_sel = slot_in ? slot_len_r[RW'(in_read_slot)] : 6'd0;

  always_ff @(posedge clk) begin
    if (read_acc) begin
      rd_slot_r <= in_read_slot;
      rd_len_r  <= len_sel;
      rd_ok_r   <= slot_in && (6'(in_read_position) < len_sel)
                && (8'(in_read_position) < KEEP_V);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_read) begin
      res_kind_r <= prsr_pkg::KIND_READ;
      res_slot_r <= rd_slot_r;
      res_data_r <= rd_ok_r ? tbl_rdata : 8'd0;
      res_len_r  <= rd_len_r;
    end else if (cmd.res_ignore) begin
      res_kind_r <= prsr_pkg::KIND_IGNORED;
      res_slot_r <= '0;
      res_data_r <= '0;
      res_len_r  <= '0;
    end else if (cmd.res_record) begin
      res_kind_r <= prsr_pkg::KIND_RECORDED;
      res_slot_r <= 4'(rem_r);
      res_data_r <= '0;
      res_len_r  <= stored_len;
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind_r <= res_kind_r;
      out_slot_r <= res_slot_r;
      out_data_r <= res_data_r;
      out_len_r  <= res_len_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_slot   = out_slot_r;
  assign out_data   = out_data_r;
  assign out_length = out_len_r;

endmodule

`default_nettype wire

// File: rtl/probe_request_ssid_recorder_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake      Beat contents
// in_ch    in   valid / ready  command, byte_value, last_byte, read_slot, read_position
// out_ch   out  valid / ready  kind, slot, data, length
//
// A frame byte that is not the last leaves the block idle; the next beat is taken right after.
// A read command runs in three steps: accept with table RAM read, result staging, load.
// A last frame byte is checked and, for a frame that is ignored, goes straight to the load;
// a recorded one first takes the reciprocal-multiply remainder (sum mod SLOTS), then per
// stored SSID byte a staging RAM read followed by the table write, then finish and load.
// Reset clears the frame state and the slot lengths at once; no clearing pass is run.
// A result waits in the output register; only a new result stalls on out_ch.ready.

module probe_request_ssid_recorder_unit #(
  parameter int SLOTS      = 16,
  parameter int SSID_BYTES = 33
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  prsr_in_if.sink    in_ch,
  prsr_out_if.source out_ch
);

  prsr_pkg::prsr_cmd_t cmd;
  prsr_pkg::prsr_sts_t sts;

  // Sequencer: decides what the datapath does in each cycle
  prsr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_last    (in_ch.last_byte),
    .in_ready   (in_ch.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Frame tracking, staging RAM, SSID table, slot lengths and output register
  prsr_dpath #(
    .SLOTS      (SLOTS),
    .SSID_BYTES (SSID_BYTES)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_command       (in_ch.command),
    .in_byte_value    (in_ch.byte_value),
    .in_read_slot     (in_ch.read_slot),
    .in_read_position (in_ch.read_position),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_kind         (out_ch.kind),
    .out_slot         (out_ch.slot),
    .out_data         (out_ch.data),
    .out_length       (out_ch.length)
  );

  // A frame byte that ends nothing must leave the block ready for the next beat
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && !in_ch.command && !in_ch.last_byte) |=> in_ch.ready)
    else $error("block not ready after a mid-frame byte");

  // Never overwrite a result that is still waiting on the output
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten");

  // Record a slot only right after the last staged byte was copied
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_record |-> $past(cmd.copy_wr && sts.copy_last))
    else $error("slot recorded before copy finished");

  // Every table write follows a staging RAM read
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.copy_wr |-> $past(cmd.copy_rd))
    else $error("table write without staged data");

endmodule

`default_nettype wire
